### sv/qdec_pkg.sv
// Shared types, constants and decode functions for the quadrature decoder.
package qdec_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int POS_WIDTH   = 8;
    localparam int FIELD_WIDTH = 16;
    localparam int SEL_WIDTH   = 8;

    // Phase codes; zero means no previous sample has been seen.
    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_1    = 3'd1;
    localparam logic [2:0] CODE_2    = 3'd2;
    localparam logic [2:0] CODE_3    = 3'd3;
    localparam logic [2:0] CODE_4    = 3'd4;

    // Output select codes.
    localparam logic [1:0] SEL_POS1   = 2'd0;
    localparam logic [1:0] SEL_POS2   = 2'd1;
    localparam logic [1:0] SEL_SPEED1 = 2'd2;
    localparam logic [1:0] SEL_SPEED2 = 2'd3;

    localparam logic [POS_WIDTH-1:0]   POS_MAX     = 8'd255;
    localparam logic [POS_WIDTH-1:0]   POS1_INIT   = 8'd250;
    localparam logic [POS_WIDTH-1:0]   POS2_INIT   = 8'd100;
    localparam logic [SPEED_WIDTH-1:0] SPEED_INIT  = SPEED_WIDTH'(100);

    typedef logic [2:0] t_code;

    typedef struct packed {
        logic [POS_WIDTH-1:0]   pos1;
        logic [POS_WIDTH-1:0]   pos2;
        logic [SPEED_WIDTH-1:0] speed1;
        logic [SPEED_WIDTH-1:0] speed2;
    } t_counts;

    // Gray-ordered pin pattern to phase code: 00->1, 01->2, 11->3, 10->4.
    function automatic t_code pins_to_code(input logic [1:0] pins);
        t_code code;
        case (pins)
            2'b00:   code = CODE_1;
            2'b01:   code = CODE_2;
            2'b11:   code = CODE_3;
            default: code = CODE_4;
        endcase
        return code;
    endfunction

    // Low sixteen bits of a speed counter, zero-extended if it is narrower.
    function automatic logic [FIELD_WIDTH-1:0] speed_field(
        input logic [SPEED_WIDTH-1:0] value
    );
        logic [SPEED_WIDTH+FIELD_WIDTH-1:0] ext;
        ext = {{FIELD_WIDTH{1'b0}}, value};
        return ext[FIELD_WIDTH-1:0];
    endfunction

endpackage

### sv/qdec_if.sv
// Valid/ready channel interfaces for encoder samples and decoder results.
interface qdec_sample_if;
    import qdec_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] pos1_phase;
    logic [1:0] speed1_phase;
    logic [1:0] pos2_phase;
    logic [1:0] speed2_phase;
    logic [1:0] select;

    modport source (
        output valid, pos1_phase, speed1_phase, pos2_phase, speed2_phase, select,
        input  ready
    );
    modport sink (
        input  valid, pos1_phase, speed1_phase, pos2_phase, speed2_phase, select,
        output ready
    );
endinterface

interface qdec_result_if;
    import qdec_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [SEL_WIDTH-1:0]          selected_value;
    logic [POS_WIDTH-1:0]          pos1_count;
    logic [POS_WIDTH-1:0]          pos2_count;
    logic signed [FIELD_WIDTH-1:0] speed1_count;
    logic signed [FIELD_WIDTH-1:0] speed2_count;

    modport source (
        output valid, selected_value, pos1_count, pos2_count, speed1_count,
               speed2_count,
        input  ready
    );
    modport sink (
        input  valid, selected_value, pos1_count, pos2_count, speed1_count,
               speed2_count,
        output ready
    );
endinterface

### sv/qdec_pos_lane.sv
// Position lane: one saturating count per full quadrature cycle.
module qdec_pos_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_phase,
    input  logic [qdec_pkg::POS_WIDTH-1:0] i_init_count,
    output logic [qdec_pkg::POS_WIDTH-1:0] o_next_count
);
    import qdec_pkg::*;

    t_code                r_prev;
    logic [POS_WIDTH-1:0] r_count;
    t_code                n_prev;
    logic [POS_WIDTH-1:0] n_count;

    always_comb begin
        n_prev  = pins_to_code(i_phase);
        n_count = r_count;
        if (r_prev == CODE_1 && n_prev == CODE_4) begin
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end else if (r_prev == CODE_4 && n_prev == CODE_1) begin
            if (r_count != POS_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign o_next_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= CODE_NONE;
            r_count <= i_init_count;
        end else if (i_accept) begin
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

endmodule

### sv/qdec_speed_lane.sv
// Speed lane: counts every phase transition up or down on a wrapping counter.
module qdec_speed_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [1:0]                      i_phase,
    output logic [qdec_pkg::SPEED_WIDTH-1:0] o_next_count
);
    import qdec_pkg::*;

    t_code                  r_prev;
    logic [SPEED_WIDTH-1:0] r_count;
    t_code                  n_prev;
    logic [SPEED_WIDTH-1:0] n_count;
    t_code                  up_code;
    t_code                  down_code;

    // Forward and reverse neighbours of the previous code; none before the first sample.
    always_comb begin
        case (r_prev)
            CODE_1: begin
                up_code   = CODE_2;
                down_code = CODE_4;
            end
            CODE_2: begin
                up_code   = CODE_3;
                down_code = CODE_1;
            end
            CODE_3: begin
                up_code   = CODE_4;
                down_code = CODE_2;
            end
            CODE_4: begin
                up_code   = CODE_1;
                down_code = CODE_3;
            end
            default: begin
                up_code   = CODE_NONE;
                down_code = CODE_NONE;
            end
        endcase
    end

    always_comb begin
        n_prev  = pins_to_code(i_phase);
        n_count = r_count;
        if (up_code != CODE_NONE && n_prev == up_code) begin
            n_count = r_count + 1'b1;
        end else if (down_code != CODE_NONE && n_prev == down_code) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_next_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= CODE_NONE;
            r_count <= SPEED_INIT;
        end else if (i_accept) begin
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

endmodule

### sv/qdec_merge.sv
// Merge stage: picks the selected counter and holds the result beat.
module qdec_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_select,
    input  qdec_pkg::t_counts     i_counts,
    qdec_result_if.source         o_result
);
    import qdec_pkg::*;

    logic                   r_valid;
    logic [SEL_WIDTH-1:0]   r_selected;
    t_counts                r_counts;
    logic [SEL_WIDTH-1:0]   n_selected;

    always_comb begin
        case (i_select)
            SEL_POS1:   n_selected = i_counts.pos1;
            SEL_POS2:   n_selected = i_counts.pos2;
            SEL_SPEED1: n_selected = i_counts.speed1[SEL_WIDTH-1:0];
            SEL_SPEED2: n_selected = i_counts.speed2[SEL_WIDTH-1:0];
            default:    n_selected = i_counts.pos1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_selected <= n_selected;
            r_counts   <= i_counts;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.selected_value = r_selected;
    assign o_result.pos1_count     = r_counts.pos1;
    assign o_result.pos2_count     = r_counts.pos2;
    assign o_result.speed1_count   = speed_field(r_counts.speed1);
    assign o_result.speed2_count   = speed_field(r_counts.speed2);

endmodule

### sv/four_channel_quadrature_decoder.sv
// Top level of the four-channel quadrature decoder.
//
// Usage: each beat on i_sample carries one sample of the A/B pins of two
// position encoders and two speed encoders, plus a two-bit select. Every
// accepted sample yields exactly one beat on o_result with all four counts
// after that sample and the low byte of the counter that select names.
// Position counters step once per full cycle and saturate at 0 and 255;
// speed counters count every phase transition in either direction and wrap.
// The result of a sample accepted at one edge is registered by the merge
// stage and valid from that edge on. Throughput is one sample per cycle
// while the receiver takes every beat, set by the single result register
// of the merge stage, reloaded when it is empty or being emptied that cycle.
// When the receiver stalls, the result beat holds and i_sample.ready falls,
// so no sample is lost. Reset clears the result valid flag and forgets the
// previous phase of every lane, so the first sample after reset only seeds
// the lanes and never counts; the counters restart at 250, 100, 100, 100.
module four_channel_quadrature_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qdec_sample_if.sink    i_sample,
    qdec_result_if.source  o_result
);
    import qdec_pkg::*;

    logic    accept;
    t_counts counts;

    // The output register accepts a new beat while it is empty or being read.
    assign i_sample.ready = !o_result.valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    // Four lanes work side by side on the four pin pairs of each sample.
    qdec_pos_lane u_pos1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_phase      (i_sample.pos1_phase),
        .i_init_count (POS1_INIT),
        .o_next_count (counts.pos1)
    );

    qdec_pos_lane u_pos2 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_phase      (i_sample.pos2_phase),
        .i_init_count (POS2_INIT),
        .o_next_count (counts.pos2)
    );

    qdec_speed_lane u_speed1 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_phase      (i_sample.speed1_phase),
        .o_next_count (counts.speed1)
    );

    qdec_speed_lane u_speed2 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_phase      (i_sample.speed2_phase),
        .o_next_count (counts.speed2)
    );

    // The merge stage registers the counts and the selected byte as one beat.
    qdec_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_select (i_sample.select),
        .i_counts (counts),
        .o_result (o_result)
    );

endmodule
